// File: src/stq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the sorted timer queue
package stq_pkg;

    localparam int MAX_TIMERS_DEF = 16;
    localparam int ID_COUNT       = 16;
    localparam int ID_W           = 4;
    localparam int TMO_W          = 31;
    localparam int CNT_OUT_W      = 5;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_NEG  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_PREV,
        RD_CUR
    } rd_sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ADD_RD,
        S_ADD_CMP,
        S_REM_RD,
        S_REM_CMP,
        S_HEAD_RD,
        S_HEAD_WAIT
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [TMO_W-1:0] tmo;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    add_init;
        logic    rem_init;
        rd_sel_t rd_sel;
        logic    wr_new;
        logic    wr_shift;
        logic    rem_step;
        logic    rem_fin;
        logic    set_status;
        status_t status_code;
        logic    out_load;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_remove;
        logic neg;
        logic queued;
        logic full;
        logic k_zero;
        logic k_end;
        logic later;
    } dp_stat_t;

endpackage

// File: src/stq_datapath.sv
`timescale 1ns / 1ps
// list memory, counters, id flags and result registers of the timer queue
module stq_datapath #(
    parameter int MAX_TIMERS = stq_pkg::MAX_TIMERS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  stq_pkg::ctl_cmd_t            ctl,
    output stq_pkg::dp_stat_t            stat,
    input  logic                         in_cmd,
    input  logic [stq_pkg::ID_W-1:0]     in_id,
    input  logic signed [31:0]           in_timeout,
    output logic [1:0]                   out_status,
    output logic                         out_head_valid,
    output logic [stq_pkg::ID_W-1:0]     out_head_id,
    output logic [stq_pkg::TMO_W-1:0]    out_head_tmo,
    output logic [stq_pkg::CNT_OUT_W-1:0] out_count
);
    import stq_pkg::*;

    localparam int ADDR_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W  = $clog2(MAX_TIMERS + 1);

    entry_t mem [MAX_TIMERS];
    entry_t rdata_reg;

    logic              cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic              neg_reg;
    logic [TMO_W-1:0]  tmo_reg;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  km1;
    logic              found_reg, found_next;
    logic [ID_COUNT-1:0] flags_reg, flags_next;
    status_t           status_reg;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;

    logic [1:0]        ostat_reg;
    logic              ohv_reg;
    logic [ID_W-1:0]   oid_reg;
    logic [TMO_W-1:0]  otmo_reg;
    logic [CNT_OUT_W-1:0] ocnt_reg;

    assign km1 = k_reg - 1'b1;

    always_comb begin
        unique case (ctl.rd_sel)
            RD_PREV: raddr = km1[ADDR_W-1:0];
            RD_CUR:  raddr = k_reg[ADDR_W-1:0];
            default: raddr = '0;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = k_reg[ADDR_W-1:0];
        wdata = rdata_reg;
        if (ctl.wr_new) begin
            we    = 1'b1;
            wdata = '{id: id_reg, tmo: tmo_reg};
        end else if (ctl.wr_shift) begin
            we = 1'b1;
        end else if (ctl.rem_step && found_reg) begin
            // close the gap left by the removed entry
            we    = 1'b1;
            waddr = km1[ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb begin
        k_next     = k_reg;
        count_next = count_reg;
        found_next = found_reg;
        flags_next = flags_reg;
        if (ctl.add_init) begin
            k_next = count_reg;
        end
        if (ctl.rem_init) begin
            k_next     = '0;
            found_next = 1'b0;
        end
        if (ctl.wr_new) begin
            count_next         = count_reg + 1'b1;
            flags_next[id_reg] = 1'b1;
        end
        if (ctl.wr_shift) begin
            k_next = km1;
        end
        if (ctl.rem_step) begin
            k_next     = k_reg + 1'b1;
            found_next = found_reg | (rdata_reg.id == id_reg);
        end
        if (ctl.rem_fin) begin
            count_next         = count_reg - 1'b1;
            flags_next[id_reg] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            flags_reg <= '0;
            found_reg <= 1'b0;
            k_reg     <= '0;
        end else begin
            count_reg <= count_next;
            flags_reg <= flags_next;
            found_reg <= found_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg <= in_cmd;
            id_reg  <= in_id;
            neg_reg <= in_timeout[31];
            tmo_reg <= in_timeout[TMO_W-1:0];
        end
        if (ctl.set_status) begin
            status_reg <= ctl.status_code;
        end
        if (ctl.out_load) begin
            ostat_reg <= status_reg;
            ohv_reg   <= (count_reg != '0);
            oid_reg   <= (count_reg != '0) ? rdata_reg.id : '0;
            otmo_reg  <= (count_reg != '0) ? rdata_reg.tmo : '0;
            ocnt_reg  <= CNT_OUT_W'(count_reg);
        end
    end

    assign stat.is_remove = (cmd_reg == CMD_REMOVE);
    assign stat.neg       = neg_reg;
    assign stat.queued    = flags_reg[id_reg];
    assign stat.full      = (count_reg >= CNT_W'(MAX_TIMERS));
    assign stat.k_zero    = (k_reg == '0);
    assign stat.k_end     = (k_reg == count_reg);
    assign stat.later     = (rdata_reg.tmo > tmo_reg);

    assign out_status     = ostat_reg;
    assign out_head_valid = ohv_reg;
    assign out_head_id    = oid_reg;
    assign out_head_tmo   = otmo_reg;
    assign out_count      = ocnt_reg;

endmodule

// File: src/stq_ctrl.sv
`timescale 1ns / 1ps
// command sequencer for the timer queue
module stq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output stq_pkg::ctl_cmd_t  ctl,
    input  stq_pkg::dp_stat_t  stat
);
    import stq_pkg::*;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        ctl         = '0;
        ctl.rd_sel  = RD_HEAD;
        s_ready     = 1'b0;
        if (ovalid_reg && m_ready) begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                ctl.set_status = 1'b1;
                if (stat.is_remove) begin
                    ctl.status_code = ST_OK;
                    if (stat.queued) begin
                        ctl.rem_init = 1'b1;
                        state_next   = S_REM_RD;
                    end else begin
                        state_next = S_HEAD_RD;
                    end
                end else if (stat.neg) begin
                    ctl.status_code = ST_NEG;
                    state_next      = S_HEAD_RD;
                end else if (stat.queued) begin
                    ctl.status_code = ST_DUP;
                    state_next      = S_HEAD_RD;
                end else if (stat.full) begin
                    ctl.status_code = ST_FULL;
                    state_next      = S_HEAD_RD;
                end else begin
                    ctl.status_code = ST_OK;
                    ctl.add_init    = 1'b1;
                    state_next      = S_ADD_RD;
                end
            end
            S_ADD_RD: begin
                if (stat.k_zero) begin
                    ctl.wr_new = 1'b1;
                    state_next = S_HEAD_RD;
                end else begin
                    ctl.rd_sel = RD_PREV;
                    state_next = S_ADD_CMP;
                end
            end
            S_ADD_CMP: begin
                // strictly later entries move up one slot
                if (stat.later) begin
                    ctl.wr_shift = 1'b1;
                    state_next   = S_ADD_RD;
                end else begin
                    ctl.wr_new = 1'b1;
                    state_next = S_HEAD_RD;
                end
            end
            S_REM_RD: begin
                if (stat.k_end) begin
                    ctl.rem_fin = 1'b1;
                    state_next  = S_HEAD_RD;
                end else begin
                    ctl.rd_sel = RD_CUR;
                    state_next = S_REM_CMP;
                end
            end
            S_REM_CMP: begin
                ctl.rem_step = 1'b1;
                state_next   = S_REM_RD;
            end
            S_HEAD_RD: begin
                state_next = S_HEAD_WAIT;
            end
            S_HEAD_WAIT: begin
                if (!ovalid_reg || m_ready) begin
                    ctl.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = ovalid_reg;

endmodule

// File: src/sorted_timer_queue_unit.sv
`timescale 1ns / 1ps
// top level of the sorted timer queue
//
//  channel | ports                                             | dir | handshake
//  --------+---------------------------------------------------+-----+----------------
//  command | s_cmd s_timer_id s_timeout_ms                     | in  | s_valid/s_ready
//  result  | m_status m_head_valid m_head_id m_head_timeout_ms | out | m_valid/m_ready
//          | m_queued_count                                    |     |
//
// add moves every queued entry with a later timeout up one slot, then writes the new entry;
// remove of a queued timer steps through the whole list, moving each entry behind it down;
// other commands only read the head. the list memory has one read and one write port.
// aresetn clears the count and the per-id flags; the list memory is not cleared.
// the result sits in an output register, so a new word is taken while it waits.
module sorted_timer_queue_unit #(
    parameter int MAX_TIMERS = stq_pkg::MAX_TIMERS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [stq_pkg::ID_W-1:0]      s_timer_id,
    input  logic signed [31:0]            s_timeout_ms,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic                          m_head_valid,
    output logic [stq_pkg::ID_W-1:0]      m_head_id,
    output logic [stq_pkg::TMO_W-1:0]     m_head_timeout_ms,
    output logic [stq_pkg::CNT_OUT_W-1:0] m_queued_count
);
    import stq_pkg::*;

    ctl_cmd_t ctl;
    dp_stat_t stat;

    stq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl),
        .stat    (stat)
    );

    stq_datapath #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (ctl),
        .stat           (stat),
        .in_cmd         (s_cmd),
        .in_id          (s_timer_id),
        .in_timeout     (s_timeout_ms),
        .out_status     (m_status),
        .out_head_valid (m_head_valid),
        .out_head_id    (m_head_id),
        .out_head_tmo   (m_head_timeout_ms),
        .out_count      (m_queued_count)
    );

`ifndef SYNTHESIS
    a_head_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_head_valid == (m_queued_count != '0)))
        else $error("head valid disagrees with queued count");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("new word taken while a command is in progress");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_FULL)) |-> (m_queued_count == CNT_OUT_W'(MAX_TIMERS)))
        else $error("queue full reported below capacity");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(ctl.wr_new || ctl.wr_shift || ctl.rem_step || ctl.rem_fin))
        else $error("list update while idle");
`endif

endmodule
